### rtl/core/lsc_pkg.sv
`default_nettype none
package lsc_pkg;
	// widths sized for the upper end of every parameter range
	localparam int SMP_W = 10;
	localparam int CAL_W = 8;
	localparam int VAL_W = 10;
	localparam int POS_W = 11;
	localparam int LDIV_NW = 18; // (sample - low) * full scale, full scale up to 1000
	localparam int LDIV_DW = CAL_W;
	localparam int WSUM_W = 15;  // sum of v * k over eight lanes
	localparam int DSUM_W = 13;  // sum of v over eight lanes
	localparam int MDIV_NW = 26; // 2 * unit * weighted sum
	localparam int MDIV_DW = 16; // (sensors - 1) * sum of v
	localparam int MAX_LANES = 8;

	localparam logic [0:0] OP_CAL  = 1'b0;
	localparam logic [0:0] OP_MEAS = 1'b1;

	localparam logic [0:0] REG_DARK_LINE = 1'b0;
	localparam logic [0:0] REG_THRESHOLD = 1'b1;

	localparam logic [VAL_W-1:0] THRESHOLD_RST = 10'd500;

	typedef struct packed {
		logic [VAL_W-1:0] v;
		logic             hit;
	} lane_res_t;
endpackage
`default_nettype wire

### rtl/core/lsc_if.sv
`default_nettype none
interface lsc_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [9:0] sample_0;
	logic [9:0] sample_1;
	logic [9:0] sample_2;
	logic [9:0] sample_3;
	logic [9:0] sample_4;
	logic [9:0] sample_5;
	logic [9:0] sample_6;
	logic [9:0] sample_7;
	modport source (output valid, opcode, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, input ready);
	modport sink (input valid, opcode, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lsc_out_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] position;
	logic               line_found;
	modport source (output valid, position, line_found, input ready);
	modport sink (input valid, position, line_found, output ready);
endinterface
`default_nettype wire

### rtl/core/lsc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module lsc_div #(
	parameter int NW = 18,
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### rtl/core/lsc_lane.sv
`default_nettype none
module lsc_lane #(
	parameter int SCALE_FULL = 1000
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cal,
	input  wire logic                          start,
	input  wire logic [lsc_pkg::SMP_W-1:0]     sample,
	input  wire logic                          dark_line,
	input  wire logic [lsc_pkg::VAL_W-1:0]     threshold,
	output lsc_pkg::lane_res_t                 res,
	output logic                               done
);
	localparam logic [lsc_pkg::VAL_W-1:0] SF = lsc_pkg::VAL_W'(SCALE_FULL);

	logic [lsc_pkg::CAL_W-1:0]   lo_q, hi_q, s, span, dden;
	logic [lsc_pkg::LDIV_NW-1:0] dnum, quo;
	logic                        zero_c, full_c, zero_q, full_q, ddone, done_q;
	logic [lsc_pkg::VAL_W-1:0]   v, vd;
	lsc_pkg::lane_res_t          res_q;

	assign s      = sample[lsc_pkg::SMP_W-1:2];
	assign zero_c = (hi_q <= lo_q) || (s <= lo_q);
	assign full_c = s >= hi_q;
	assign span   = hi_q - lo_q;
	assign dden   = (hi_q <= lo_q) ? lsc_pkg::CAL_W'(1) : span;
	assign dnum   = lsc_pkg::LDIV_NW'({10'b0, s - lo_q} * {8'b0, SF});

	lsc_div #(.NW(lsc_pkg::LDIV_NW), .DW(lsc_pkg::LDIV_DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(start), .num(dnum), .den(dden),
		.done(ddone), .quo(quo)
	);

	always_comb begin
		if (zero_q)      v = '0;
		else if (full_q) v = SF;
		else             v = quo[lsc_pkg::VAL_W-1:0];
		vd = dark_line ? SF - v : v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '1;
			hi_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ddone;
			if (cal) begin
				if (s < lo_q) lo_q <= s;
				if (s > hi_q) hi_q <= s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= zero_c;
			full_q <= full_c;
		end
		if (ddone) begin
			res_q.v   <= vd;
			res_q.hit <= vd >= threshold;
		end
	end

	assign res  = res_q;
	assign done = done_q;
endmodule
`default_nettype wire

### rtl/core/lsc_merge.sv
`default_nettype none
module lsc_merge #(
	parameter int NUM_SENSORS   = 8,
	parameter int POSITION_UNIT = 1000
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire lsc_pkg::lane_res_t         res [NUM_SENSORS],
	output logic                            done,
	output logic [lsc_pkg::POS_W-1:0]       position,
	output logic                            line_found
);
	localparam logic [lsc_pkg::POS_W:0] PU = (lsc_pkg::POS_W + 1)'(POSITION_UNIT);

	logic [lsc_pkg::WSUM_W-1:0]  wsum, wsum_s1;
	logic [lsc_pkg::DSUM_W-1:0]  dsum, dsum_s1;
	logic                        any, found_s1, found_s2, zden_s2, go_s1, go_s2;
	logic [lsc_pkg::MDIV_NW-1:0] num_s2, quo;
	logic [lsc_pkg::MDIV_DW-1:0] den_s2;
	logic                        dstart, ddone, done_q, found_q, lastpos_q;
	logic [lsc_pkg::POS_W-1:0]   pos_q;
	logic signed [lsc_pkg::POS_W:0] qpos;

	always_comb begin
		wsum = '0;
		dsum = '0;
		any  = 1'b0;
		for (int k = 0; k < NUM_SENSORS; k++) begin
			wsum = wsum + lsc_pkg::WSUM_W'(res[k].v) * lsc_pkg::WSUM_W'(k);
			dsum = dsum + lsc_pkg::DSUM_W'(res[k].v);
			any  = any | res[k].hit;
		end
	end

	assign dstart = go_s2 && found_s2 && !zden_s2;
	assign qpos   = $signed({1'b0, quo[lsc_pkg::POS_W-1:0]}) - $signed(PU);

	lsc_div #(.NW(lsc_pkg::MDIV_NW), .DW(lsc_pkg::MDIV_DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(num_s2), .den(den_s2),
		.done(ddone), .quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1     <= 1'b0;
			go_s2     <= 1'b0;
			done_q    <= 1'b0;
			lastpos_q <= 1'b0;
		end else begin
			go_s1  <= start;
			go_s2  <= go_s1;
			done_q <= 1'b0;
			if (go_s2 && !dstart) begin
				done_q <= 1'b1;
				// zero sum with a line seen resolves to center
				if (found_s2) lastpos_q <= 1'b0;
			end else if (ddone) begin
				done_q    <= 1'b1;
				lastpos_q <= qpos > 0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			wsum_s1  <= wsum;
			dsum_s1  <= dsum;
			found_s1 <= any;
		end
		if (go_s1) begin
			num_s2   <= lsc_pkg::MDIV_NW'(wsum_s1 * (2 * POSITION_UNIT));
			den_s2   <= lsc_pkg::MDIV_DW'(dsum_s1 * (NUM_SENSORS - 1));
			zden_s2  <= dsum_s1 == '0;
			found_s2 <= found_s1;
		end
		if (go_s2 && !dstart) begin
			found_q <= found_s2;
			if (found_s2)       pos_q <= '0;
			else if (lastpos_q) pos_q <= PU[lsc_pkg::POS_W-1:0];
			else                pos_q <= lsc_pkg::POS_W'(-$signed(PU));
		end else if (ddone) begin
			found_q <= 1'b1;
			pos_q   <= qpos[lsc_pkg::POS_W-1:0];
		end
	end

	assign done       = done_q;
	assign position   = pos_q;
	assign line_found = found_q;
endmodule
`default_nettype wire

### rtl/core/line_sensor_centroid_core.sv
`default_nettype none
// Calibrated weighted-centroid line sensor. A calibrate item (opcode 0) widens
// each sensor's stored min/max and produces no result; the next item can be
// taken on the following cycle. A measure item (opcode 1) produces one result:
// every sensor lane scales its sample with a serial divider and registers the
// lane value, registered stages sum and weight the lane values, a serial
// divider forms the centroid, and the merge done register and the wait state
// hand the result to the output register. Items with no line, or with a zero
// sum, skip the second divider. One measure is in flight at a time and the next
// item can be accepted in the same cycle as the result is offered; a finished
// result waits in the output register while the next item is accepted.
module line_sensor_centroid_core #(
	parameter int NUM_SENSORS   = 8,
	parameter int SCALE_FULL    = 1000,
	parameter int POSITION_UNIT = 1000
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lsc_in_if.sink          in_ch,
	lsc_out_if.source       out_ch,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [9:0] cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]                    st_q;
	logic                          dark_q;
	logic [lsc_pkg::VAL_W-1:0]     thr_q;
	logic                          acc, meas, cal, mdone, mfound, ovalid_q, ofound_q;
	logic [lsc_pkg::POS_W-1:0]     mpos, opos_q;
	logic [lsc_pkg::SMP_W-1:0]     smp [lsc_pkg::MAX_LANES];
	lsc_pkg::lane_res_t            lres [NUM_SENSORS];
	logic [NUM_SENSORS-1:0]        ldone;

	assign smp[0] = in_ch.sample_0;
	assign smp[1] = in_ch.sample_1;
	assign smp[2] = in_ch.sample_2;
	assign smp[3] = in_ch.sample_3;
	assign smp[4] = in_ch.sample_4;
	assign smp[5] = in_ch.sample_5;
	assign smp[6] = in_ch.sample_6;
	assign smp[7] = in_ch.sample_7;

	assign in_ch.ready = st_q == ST_IDLE;
	assign acc  = in_ch.valid && in_ch.ready;
	assign meas = acc && (in_ch.opcode == lsc_pkg::OP_MEAS);
	assign cal  = acc && (in_ch.opcode == lsc_pkg::OP_CAL);

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		lsc_lane #(.SCALE_FULL(SCALE_FULL)) u_lane (
			.clk(clk), .arst_n(arst_n), .cal(cal), .start(meas), .sample(smp[g]),
			.dark_line(dark_q), .threshold(thr_q), .res(lres[g]), .done(ldone[g])
		);
	end

	lsc_merge #(.NUM_SENSORS(NUM_SENSORS), .POSITION_UNIT(POSITION_UNIT)) u_merge (
		.clk(clk), .arst_n(arst_n), .start(&ldone), .res(lres), .done(mdone),
		.position(mpos), .line_found(mfound)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			dark_q   <= 1'b0;
			thr_q    <= lsc_pkg::THRESHOLD_RST;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lsc_pkg::REG_DARK_LINE: dark_q <= cfg_data[0];
					lsc_pkg::REG_THRESHOLD: thr_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_ch.ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (meas) st_q <= ST_BUSY;
				ST_BUSY: if (mdone) st_q <= ST_WAIT;
				ST_WAIT: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WAIT && (!ovalid_q || out_ch.ready)) begin
			opos_q   <= mpos;
			ofound_q <= mfound;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.position   = opos_q;
	assign out_ch.line_found = ofound_q;
endmodule
`default_nettype wire

### dv/lsc_tb_if.sv
`timescale 1ns / 1ps
// The block's own interfaces (rtl/core/lsc_if.sv) serve as the channels.
// This file holds the testbench's item type.
package lsc_tb_pkg;
	typedef struct packed {
		logic       opcode;
		logic [9:0] s7;
		logic [9:0] s6;
		logic [9:0] s5;
		logic [9:0] s4;
		logic [9:0] s3;
		logic [9:0] s2;
		logic [9:0] s1;
		logic [9:0] s0;
	} sense_item_t;

	typedef struct packed {
		logic signed [10:0] position;
		logic               line_found;
	} fix_t;
endpackage

### dv/tb_line_sensor_centroid_core.sv
`timescale 1ns / 1ps
module tb_line_sensor_centroid_core;
	localparam int LANES = 8;
	localparam int FULL = 1000;
	localparam int UNIT = 1000;
	localparam int LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [9:0] cfg_data;

	lsc_in_if in_ch ();
	lsc_out_if out_ch ();

	line_sensor_centroid_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] cal_lo [LANES];
	logic [7:0] cal_hi [LANES];
	logic       was_right;
	logic       dark;
	logic [9:0] thresh;

	lsc_tb_pkg::sense_item_t pending_items[$];
	lsc_tb_pkg::fix_t        expected_fixes[$];
	int          errors;
	int          shown;
	int          cycles;
	bit          stim_done;
	bit          hold_src;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic logic [9:0] sample_of(lsc_tb_pkg::sense_item_t it, int k);
		logic [79:0] flat;
		flat = it[79:0];
		return flat[k*10 +: 10];
	endfunction

	// walks the item through calibration or measurement, queueing any result
	task automatic predict_fix(lsc_tb_pkg::sense_item_t it);
		int unsigned s, v, lo, hi;
		longint unsigned num, den;
		longint pos;
		bit found;
		lsc_tb_pkg::fix_t f;
		num = 0;
		den = 0;
		found = 0;
		if (it.opcode == lsc_pkg::OP_CAL) begin
			for (int k = 0; k < LANES; k++) begin
				s = 32'(sample_of(it, k) >> 2);
				if (s < cal_lo[k]) cal_lo[k] = 8'(s);
				if (s > cal_hi[k]) cal_hi[k] = 8'(s);
			end
			return;
		end
		for (int k = 0; k < LANES; k++) begin
			s = 32'(sample_of(it, k) >> 2);
			lo = 32'(cal_lo[k]);
			hi = 32'(cal_hi[k]);
			if (hi <= lo || s <= lo) v = 0;
			else if (s >= hi) v = FULL;
			else v = (s - lo) * FULL / (hi - lo);
			if (dark) v = FULL - v;
			if (v >= thresh) found = 1;
			num += longint'(v) * k * UNIT;
			den += v;
		end
		if (found) pos = (den == 0) ? 0 : longint'((2 * num) / ((LANES - 1) * den)) - UNIT;
		else pos = was_right ? UNIT : -UNIT;
		was_right = pos > 0;
		f.position = pos[10:0];
		f.line_found = found;
		expected_fixes.push_back(f);
	endtask

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) predict_fix(lsc_tb_pkg::sense_item_t'({
				in_ch.opcode,
				in_ch.sample_7, in_ch.sample_6, in_ch.sample_5, in_ch.sample_4,
				in_ch.sample_3, in_ch.sample_2, in_ch.sample_1, in_ch.sample_0}));
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap > 0 || hold_src || pending_items.size() == 0) begin
					in_ch.valid <= 1'b0;
					if (src_gap > 0) src_gap <= src_gap - 1;
				end else begin
					lsc_tb_pkg::sense_item_t it;
					it = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					{in_ch.opcode, in_ch.sample_7, in_ch.sample_6, in_ch.sample_5,
						in_ch.sample_4, in_ch.sample_3, in_ch.sample_2, in_ch.sample_1,
						in_ch.sample_0} <= it;
					src_gap <= rand_gap();
				end
			end
		end
	end

	// monitor
	int sink_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_fixes.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("unexpected result pos=%0d found=%0b",
							out_ch.position, out_ch.line_found);
					end
				end else begin
					lsc_tb_pkg::fix_t e;
					e = expected_fixes.pop_front();
					if (e.position !== out_ch.position || e.line_found !== out_ch.line_found) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("mismatch: exp pos=%0d found=%0b got pos=%0d found=%0b",
								e.position, e.line_found, out_ch.position, out_ch.line_found);
						end
					end
				end
			end
			if (sink_gap > 0) begin
				out_ch.ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				out_ch.ready <= 1'b1;
				sink_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_line_sensor_centroid_core NOT OK");
			$finish;
		end
	end

	function automatic lsc_tb_pkg::sense_item_t make_item(logic op, logic [9:0] base,
		int spread);
		lsc_tb_pkg::sense_item_t it;
		logic [79:0] flat;
		for (int k = 0; k < LANES; k++) begin
			int x;
			x = int'(base) + $urandom_range(0, 2 * spread) - spread;
			if (x < 0) x = 0;
			if (x > 1023) x = 1023;
			flat[k*10 +: 10] = 10'(x);
		end
		it[79:0] = flat;
		it.opcode = op;
		return it;
	endfunction

	function automatic lsc_tb_pkg::sense_item_t line_item(int center, int width);
		lsc_tb_pkg::sense_item_t it;
		logic [79:0] flat;
		for (int k = 0; k < LANES; k++) begin
			int d;
			d = (k > center) ? k - center : center - k;
			flat[k*10 +: 10] = (d <= width) ? 10'($urandom_range(700, 1023)) :
				10'($urandom_range(0, 300));
		end
		it[79:0] = flat;
		it.opcode = lsc_pkg::OP_MEAS;
		return it;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_ch.valid || expected_fixes.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [9:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lsc_pkg::REG_DARK_LINE) dark = val[0];
		else thresh = val;
	endtask

	initial begin
		lsc_tb_pkg::sense_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lsc_pkg::REG_DARK_LINE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = lsc_pkg::OP_CAL;
		{in_ch.sample_0, in_ch.sample_1, in_ch.sample_2, in_ch.sample_3} = '0;
		{in_ch.sample_4, in_ch.sample_5, in_ch.sample_6, in_ch.sample_7} = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		shown = 0;
		cycles = 0;
		hold_src = 0;
		for (int k = 0; k < LANES; k++) begin
			cal_lo[k] = 8'd255;
			cal_hi[k] = 8'd0;
		end
		was_right = 0;
		dark = 0;
		thresh = lsc_pkg::THRESHOLD_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// uncalibrated measures: everything scales to zero
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd1023, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		// calibrate to full range, then extremes and a few lines
		pending_items.push_back(make_item(lsc_pkg::OP_CAL, 10'd0, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_CAL, 10'd1023, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd1023, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		for (int c = 0; c < LANES; c++) pending_items.push_back(line_item(c, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		wait_idle();
		// threshold zero with all-zero values: found with zero sum
		write_reg(lsc_pkg::REG_THRESHOLD, 10'd0);
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		pending_items.push_back(line_item(7, 1));
		wait_idle();
		// unreachable threshold, dark line
		write_reg(lsc_pkg::REG_THRESHOLD, 10'd1023);
		write_reg(lsc_pkg::REG_DARK_LINE, 10'd1);
		pending_items.push_back(line_item(6, 0));
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		wait_idle();
		write_reg(lsc_pkg::REG_THRESHOLD, 10'd1000);
		pending_items.push_back(make_item(lsc_pkg::OP_MEAS, 10'd0, 0));
		pending_items.push_back(line_item(2, 1));
		wait_idle();

		// random phases: fresh state is not reachable, so vary settings and
		// let calibration keep widening from random items
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(lsc_pkg::REG_DARK_LINE, 10'($urandom_range(0, 1)));
			case (ph % 4)
				0: write_reg(lsc_pkg::REG_THRESHOLD, 10'd1);
				1: write_reg(lsc_pkg::REG_THRESHOLD, 10'($urandom_range(0, 1023)));
				2: write_reg(lsc_pkg::REG_THRESHOLD, 10'd999);
				default: write_reg(lsc_pkg::REG_THRESHOLD, 10'($urandom_range(200, 800)));
			endcase
			for (int n = 0; n < 200; n++) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 10) it = make_item(lsc_pkg::OP_CAL, 10'($urandom_range(0, 1023)),
					$urandom_range(0, 200));
				else if (r < 70) it = line_item($urandom_range(0, 7), $urandom_range(0, 2));
				else begin
					it = lsc_tb_pkg::sense_item_t'(81'({$urandom, $urandom, $urandom}));
					it.opcode = $urandom_range(0, 3) != 0;
				end
				pending_items.push_back(it);
				if (n == 100 && ph == 3) begin
					// sender holds until every result is back
					while (pending_items.size() != 0 || in_ch.valid) @(posedge clk);
					hold_src = 1;
					while (expected_fixes.size() != 0) @(posedge clk);
					hold_src = 0;
				end
			end
			wait_idle();
		end

		if (errors == 0)
			$display("tb_line_sensor_centroid_core OK");
		else
			$display("tb_line_sensor_centroid_core NOT OK");
		$finish;
	end
endmodule
